>>> rtl/vbc_pkg.sv
`timescale 1ns / 1ps
// Package for the voxel boundary classifier: beat types, codes, constants and helpers.
package vbc_pkg;

    localparam int DEF_GRID_X = 32;
    localparam int DEF_GRID_Y = 32;
    localparam int DEF_GRID_Z = 32;
    localparam int ZMAX       = 64;

    localparam logic [3:0] STEP_RESET = 4'd2;
    localparam int         NBR_COUNT  = 8;

    typedef enum logic [1:0] {
        FN_WR_TRAV  = 2'd0,
        FN_WR_FORB  = 2'd1,
        FN_WR_OCC   = 2'd2,
        FN_CLASSIFY = 2'd3
    } t_func;

    typedef struct packed {
        t_func      func;
        logic [4:0] cell_x;
        logic [4:0] cell_y;
        logic [4:0] cell_z;
        logic       bit_value;
    } t_in_item;

    typedef struct packed {
        logic is_traversable;
        logic on_boundary;
        logic dropoff_edge;
        logic wall_edge;
        logic forbidden_edge;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic acc;
        logic nbr_ok;
    } t_flg_ctl;

    function automatic logic signed [1:0] f_nbr_dx(input logic [2:0] k);
        logic signed [1:0] d;
        unique case (k)
            3'd0, 3'd1, 3'd2: d = -2'sd1;
            3'd3, 3'd4:       d = 2'sd0;
            default:          d = 2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] f_nbr_dy(input logic [2:0] k);
        logic signed [1:0] d;
        unique case (k)
            3'd0, 3'd5: d = -2'sd1;
            3'd1, 3'd6: d = 2'sd0;
            3'd2, 3'd7: d = 2'sd1;
            3'd3:       d = -2'sd1;
            default:    d = 2'sd1;
        endcase
        return d;
    endfunction

    // bits lo..hi inclusive; caller slices to the grid height
    function automatic logic [ZMAX-1:0] f_span(input logic signed [7:0] lo,
                                               input logic signed [7:0] hi);
        logic [ZMAX-1:0] m;
        for (int i = 0; i < ZMAX; i++) begin
            m[i] = (int'(lo) <= i) && (i <= int'(hi));
        end
        return m;
    endfunction

endpackage

>>> rtl/vbc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module vbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/vbc_flags.sv
`timescale 1ns / 1ps
// Span masks and edge-flag accumulation over the eight neighbour columns.
module vbc_flags #(
    parameter int GRID_Z = vbc_pkg::DEF_GRID_Z
) (
    input  logic              i_clk,
    input  vbc_pkg::t_flg_ctl i_ctl,
    input  logic [4:0]        i_z,
    input  logic [3:0]        i_step,
    input  logic [GRID_Z-1:0] i_trav_col,
    input  logic [GRID_Z-1:0] i_forb_col,
    input  logic [GRID_Z-1:0] i_occ_col,
    output logic              o_drop,
    output logic              o_forb,
    output logic              o_wall
);
    import vbc_pkg::*;

    logic [GRID_Z-1:0] r_near_m;
    logic [GRID_Z-1:0] r_wall_m;
    logic [GRID_Z-1:0] r_level_m;
    logic              r_drop;
    logic              r_forb;
    logic              r_wall;

    logic signed [7:0] zs;
    logic signed [7:0] ss;
    logic [ZMAX-1:0]   near_full;
    logic [ZMAX-1:0]   wall_full;
    logic [ZMAX-1:0]   level_full;
    logic [GRID_Z-1:0] trav_c;
    logic [GRID_Z-1:0] forb_c;
    logic [GRID_Z-1:0] occ_c;

    always_comb begin
        zs         = signed'({3'b000, i_z});
        ss         = signed'({4'b0000, (i_step == 4'd0) ? 4'd1 : i_step});
        near_full  = f_span(zs - ss, zs + ss);
        wall_full  = f_span(zs + 8'sd1, zs + ss + 8'sd2);
        level_full = f_span(zs, zs);
        // out-of-plane neighbours read as empty columns
        trav_c     = i_ctl.nbr_ok ? i_trav_col : '0;
        forb_c     = i_ctl.nbr_ok ? i_forb_col : '0;
        occ_c      = i_ctl.nbr_ok ? i_occ_col  : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_near_m  <= near_full[GRID_Z-1:0];
            r_wall_m  <= wall_full[GRID_Z-1:0];
            r_level_m <= level_full[GRID_Z-1:0];
            r_drop    <= 1'b0;
            r_forb    <= 1'b0;
            r_wall    <= 1'b0;
        end else if (i_ctl.acc) begin
            r_drop <= r_drop | ((trav_c & r_near_m) == '0);
            r_forb <= r_forb | ((forb_c & r_level_m) != '0);
            r_wall <= r_wall | ((occ_c & r_wall_m) != '0);
        end
    end

    assign o_drop = r_drop;
    assign o_forb = r_forb;
    assign o_wall = r_wall;

endmodule

>>> rtl/voxel_boundary_classifier.sv
`timescale 1ns / 1ps
// Top level of the voxel boundary classifier.
//
// Input beats arrive on i_in_valid / o_in_ready carrying func, x, y, z and a
// bit value. Write beats (traversable, forbidden, occupied) set or clear one
// voxel and give no result; a write out of the grid is dropped. Classify
// beats give one result beat on o_out_valid / i_out_ready.
// Each map is one RAM of GRID_X*GRID_Y column words, GRID_Z bits wide.
// A write is a read-modify-write: read on acceptance, written back in ST_WRITE.
// A classify reads the own column, then one neighbour column per cycle from
// all three RAMs (up to eight reads, one per in-grid neighbour): the result is
// registered in ST_DONE once the output register is free, and the next beat is
// taken in the cycle after. The single RAM read port per map makes reads serial.
// After reset a clearing pass writes zero to every one of the GRID_X*GRID_Y
// entries (1024 by default), with o_in_ready low; the step register resets
// to 2 and may be written at any time through i_cfg_valid (always ready).
// The result sits in an output register: while the receiver stalls the
// block still takes and performs writes, and a finished classify waits in
// its last state until the output register is free.
module voxel_boundary_classifier #(
    parameter int GRID_X = vbc_pkg::DEF_GRID_X,
    parameter int GRID_Y = vbc_pkg::DEF_GRID_Y,
    parameter int GRID_Z = vbc_pkg::DEF_GRID_Z
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vbc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vbc_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data
);
    import vbc_pkg::*;

    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int ZW    = $clog2(GRID_Z);

    t_state     r_state, n_state;
    t_in_item   r_item;
    logic [3:0] r_idx;
    logic [AW-1:0] r_clr_addr;
    logic [3:0] r_step;
    logic       r_self_ok;
    logic       r_trav;
    logic       r_nbr_ok;
    logic       r_out_valid;
    t_out_item  r_out;

    logic              in_acc;
    logic              out_acc;
    logic              in_self_ok;
    logic [AW-1:0]     in_addr;
    logic [AW-1:0]     self_addr;
    int                nx, ny;
    logic              nbr_ok;
    logic [AW-1:0]     nbr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              we_t, we_f, we_o;
    logic [AW-1:0]     wr_addr;
    logic [GRID_Z-1:0] wr_data;
    logic [GRID_Z-1:0] sel_col;
    logic [GRID_Z-1:0] rd_t, rd_f, rd_o;
    logic              load_out;
    t_flg_ctl          flg_ctl;
    logic              drop, forb, wall;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;

    always_comb begin
        in_self_ok = (int'(i_in.cell_x) < GRID_X) && (int'(i_in.cell_y) < GRID_Y)
                     && (int'(i_in.cell_z) < GRID_Z);
        in_addr    = AW'(int'(i_in.cell_x) * GRID_Y + int'(i_in.cell_y));
        self_addr  = AW'(int'(r_item.cell_x) * GRID_Y + int'(r_item.cell_y));
        nx         = int'(r_item.cell_x) + int'(f_nbr_dx(r_idx[2:0]));
        ny         = int'(r_item.cell_y) + int'(f_nbr_dy(r_idx[2:0]));
        nbr_ok     = (nx >= 0) && (nx < GRID_X) && (ny >= 0) && (ny < GRID_Y);
        nbr_addr   = AW'(nx * GRID_Y + ny);
    end

    always_comb begin
        unique case (r_item.func)
            FN_WR_TRAV:             sel_col = rd_t;
            FN_WR_FORB:             sel_col = rd_f;
            FN_WR_OCC, FN_CLASSIFY: sel_col = rd_o;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        rd_en    = 1'b0;
        rd_addr  = in_addr;
        we_t     = 1'b0;
        we_f     = 1'b0;
        we_o     = 1'b0;
        wr_addr  = self_addr;
        wr_data  = sel_col;
        load_out = 1'b0;
        flg_ctl  = '{start: 1'b0, acc: 1'b0, nbr_ok: r_nbr_ok};
        unique case (r_state)
            ST_CLEAR: begin
                we_t    = 1'b1;
                we_f    = 1'b1;
                we_o    = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                rd_en = in_acc;
                if (in_acc) begin
                    n_state = (i_in.func == FN_CLASSIFY) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_WRITE: begin
                wr_data[ZW'(r_item.cell_z)] = r_item.bit_value;
                we_t    = r_self_ok && (r_item.func == FN_WR_TRAV);
                we_f    = r_self_ok && (r_item.func == FN_WR_FORB);
                we_o    = r_self_ok && (r_item.func == FN_WR_OCC);
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                rd_addr       = nbr_addr;
                rd_en         = nbr_ok && (r_idx < 4'(NBR_COUNT));
                flg_ctl.start = (r_idx == 4'd0);
                flg_ctl.acc   = (r_idx != 4'd0);
                if (r_idx == 4'(NBR_COUNT)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_step      <= STEP_RESET;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid) begin
                r_step <= i_cfg_data;
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + 4'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item    <= i_in;
            r_self_ok <= in_self_ok;
        end
        if (r_state == ST_SCAN) begin
            r_nbr_ok <= nbr_ok;
            if (r_idx == 4'd0) begin
                r_trav <= r_self_ok && rd_t[ZW'(r_item.cell_z)];
            end
        end
        if (load_out) begin
            r_out.is_traversable <= r_trav;
            r_out.on_boundary    <= r_trav && (drop || wall || forb);
            r_out.dropoff_edge   <= r_trav && drop;
            r_out.wall_edge      <= r_trav && wall;
            r_out.forbidden_edge <= r_trav && forb;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    vbc_ram #(.WIDTH(GRID_Z), .DEPTH(DEPTH)) u_ram_trav (
        .i_clk   (i_clk),
        .i_we    (we_t),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_t)
    );

    vbc_ram #(.WIDTH(GRID_Z), .DEPTH(DEPTH)) u_ram_forb (
        .i_clk   (i_clk),
        .i_we    (we_f),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_f)
    );

    vbc_ram #(.WIDTH(GRID_Z), .DEPTH(DEPTH)) u_ram_occ (
        .i_clk   (i_clk),
        .i_we    (we_o),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_o)
    );

    vbc_flags #(.GRID_Z(GRID_Z)) u_flags (
        .i_clk      (i_clk),
        .i_ctl      (flg_ctl),
        .i_z        (r_item.cell_z),
        .i_step     (r_step),
        .i_trav_col (rd_t),
        .i_forb_col (rd_f),
        .i_occ_col  (rd_o),
        .o_drop     (drop),
        .o_forb     (forb),
        .o_wall     (wall)
    );

endmodule

>>> rtl/vbc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the voxel boundary classifier, bound to the top level.
module vbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input vbc_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input vbc_pkg::t_out_item o_out
);
    import vbc_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // one item at a time: busy the cycle after any acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous item in flight");

    // non-traversable cell reports nothing else
    a_non_trav_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_traversable |->
            !o_out.on_boundary && !o_out.dropoff_edge && !o_out.wall_edge
            && !o_out.forbidden_edge)
        else $error("flags set for non-traversable cell");

    // boundary is the OR of the edge kinds
    a_boundary_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out.on_boundary == (o_out.dropoff_edge || o_out.wall_edge
                                  || o_out.forbidden_edge))
        else $error("boundary flag inconsistent with edge flags");

    // a write beat never produces a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.func != FN_CLASSIFY) && !o_out_valid
        |=> !o_out_valid)
        else $error("result produced by a write beat");

endmodule

bind voxel_boundary_classifier vbc_checker u_vbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
